>>> hdl/svst_pkg.sv
`timescale 1ns / 1ps

package svst_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_QUERY
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } back_state_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
    logic             full_error;
    logic [POS_W-1:0] count;
  } result_t;

endpackage

>>> hdl/svst_fifo.sv
`timescale 1ns / 1ps

module svst_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (fill_q == CNT_W'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/svst_front.sv
`timescale 1ns / 1ps

module svst_front
  import svst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    item_valid_o,
  output item_t                   item_o,
  input  logic                    item_ready_i
);

  logic  valid_q, valid_d;
  item_t item_q;
  op_e   op;
  logic  accept;

  always_comb begin
    unique case (kind_e'(kind_i))
      KIND_INSERT: op = OP_INSERT;
      KIND_DELETE: op = OP_DELETE;
      KIND_QUERY:  op = OP_QUERY;
      default:     op = OP_QUERY;
    endcase
  end

  assign full         = valid_q && !item_ready_i;
  assign accept       = push && !full;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op    <= op;
      item_q.value <= value_i;
    end
  end

endmodule

>>> hdl/svst_back.sv
`timescale 1ns / 1ps

module svst_back
  import svst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  item_t   in_item_i,
  output logic    in_ready_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  back_state_e         state_q, state_d;
  logic [VAL_W-1:0]    entry_q [CAPACITY];
  logic [VAL_W-1:0]    entry_d [CAPACITY];
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAPACITY-1:0] match_q, match_d;
  op_e                 op_q;
  logic [VAL_W-1:0]    value_q;
  logic                capture;
  logic                commit;
  logic                hit;
  logic [CNT_W-1:0]    pos;
  logic                ins_ok;
  logic                del_ok;
  logic                full_err;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    capture     = 1'b0;
    commit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          capture = 1'b1;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Only entries below the count take part in the search.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (entry_q[i] == in_item_i.value) && (CNT_W'(i) < count_q);
    end
  end

  always_comb begin
    hit = |match_q;
    pos = count_q;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        pos = CNT_W'(i);
      end
    end
    ins_ok   = (op_q == OP_INSERT) && !hit && (count_q < CNT_W'(CAPACITY));
    full_err = (op_q == OP_INSERT) && !hit && (count_q == CNT_W'(CAPACITY));
    del_ok   = (op_q == OP_DELETE) && hit;

    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_d = count_q - CNT_W'(1);
    end

    entry_d = entry_q;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_ok && (count_q == CNT_W'(i))) begin
        entry_d[i] = value_q;
      end
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (del_ok && (CNT_W'(i) >= pos)) begin
        entry_d[i] = entry_q[i+1];
      end
    end

    res_o.hit        = hit;
    res_o.position   = POS_W'(pos);
    res_o.full_error = full_err;
    res_o.count      = POS_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      match_q <= match_d;
      op_q    <= in_item_i.op;
      value_q <= in_item_i.value;
    end
    if (commit) begin
      entry_q <= entry_d;
    end
  end

endmodule

>>> hdl/small_value_set_table_core.sv
`timescale 1ns / 1ps

// A set of up to CAPACITY distinct 32-bit values kept in insertion order, driven
// through queue-style ports on both sides. Each beat on the input asks to insert,
// delete or look up one value (kind 3 acts as a lookup) and yields exactly one result
// beat with the hit flag, the lowest matching position (the count when absent), a
// full error for a dropped insert, and the count afterwards. The table engine handles
// one item at a time, first comparing the value with all stored entries in parallel
// and then resolving the first match and updating the table once the result queue
// has room; it takes no new item until the last one is done. Small queues sit before
// and after the engine, so input beats are taken while results wait to be popped.
// No clearing pass is needed after reset.
module small_value_set_table_core
  import svst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    empty,
  input  logic                    pop,
  output logic                    hit_o,
  output logic [POS_W-1:0]        position_o,
  output logic                    full_error_o,
  output logic [POS_W-1:0]        count_o
);

  logic    front_valid;
  item_t   front_item;
  logic    item_full;
  logic    item_empty;
  item_t   item_head;
  logic    back_ready;
  logic    res_valid;
  result_t res_item;
  logic    res_full;
  result_t res_head;

  svst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .item_valid_o (front_valid),
    .item_o       (front_item),
    .item_ready_i (!item_full)
  );

  svst_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (2)
  ) u_item_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (item_full),
    .pop_i   (back_ready),
    .data_o  (item_head),
    .empty_o (item_empty)
  );

  svst_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!item_empty),
    .in_item_i   (item_head),
    .in_ready_o  (back_ready),
    .res_valid_o (res_valid),
    .res_o       (res_item),
    .res_ready_i (!res_full)
  );

  svst_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign hit_o        = res_head.hit;
  assign position_o   = res_head.position;
  assign full_error_o = res_head.full_error;
  assign count_o      = res_head.count;

`ifndef SYNTHESIS
  a_err_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(hit_o && full_error_o))
    else $error("full error reported for a value that was present");

  a_err_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && full_error_o) |-> (count_o == POS_W'(CAPACITY)))
    else $error("full error reported while the set had room");

  a_engine_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_full) |=> (res_valid && $stable(res_item)))
    else $error("result dropped or changed while the result queue was full");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import svst_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1875;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int POOL_SIZE = 24;

  class set_table_model;
    logic [VAL_W-1:0] slots[CAPACITY];
    int unsigned stored;
    result_t replies[$];
    int unsigned errors;
    int unsigned ops;
    int unsigned hits;
    int unsigned dropped;
    int unsigned shifts;

    function void note_request(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value);
      result_t r;
      int unsigned idx;
      bit found;
      idx = stored;
      found = 1'b0;
      for (int i = 0; i < stored; i++) begin
        if (!found && slots[i] == value) begin
          idx = i;
          found = 1'b1;
        end
      end
      r.hit = found;
      r.position = idx[POS_W-1:0];
      r.full_error = 1'b0;
      if (kind == KIND_INSERT && !found) begin
        if (stored < CAPACITY) begin
          slots[stored] = value;
          stored++;
        end else begin
          r.full_error = 1'b1;
          dropped++;
        end
      end else if (kind == KIND_DELETE && found) begin
        for (int i = idx; i + 1 < stored; i++) slots[i] = slots[i + 1];
        stored--;
        shifts++;
      end
      r.count = stored[POS_W-1:0];
      ops++;
      if (found) hits++;
      replies.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= 200) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (replies.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual hit %0b position %0d",
                 $time, got.hit, got.position);
        return;
      end
      want = replies.pop_front();
      if (got.hit !== want.hit) report("hit", want.hit, got.hit);
      if (got.position !== want.position) report("position", want.position, got.position);
      if (got.full_error !== want.full_error) begin
        report("full_error", want.full_error, got.full_error);
      end
      if (got.count !== want.count) report("count", want.count, got.count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic [KIND_W-1:0] kind_i;
  logic signed [VAL_W-1:0] value_i;
  logic empty;
  logic pop;
  logic hit_o;
  logic [POS_W-1:0] position_o;
  logic full_error_o;
  logic [POS_W-1:0] count_o;

  set_table_model model;
  logic [VAL_W-1:0] pool[POOL_SIZE];
  bit no_idle;
  int hold_cycles;
  int idle_cycles;

  small_value_set_table_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .empty       (empty),
    .pop         (pop),
    .hit_o       (hit_o),
    .position_o  (position_o),
    .full_error_o(full_error_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    result_t got;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (push && !full) begin
        model.note_request(kind_i, value_i);
        moved = 1'b1;
      end
      if (pop && !empty) begin
        got.hit = hit_o;
        got.position = position_o;
        got.full_error = full_error_o;
        got.count = count_o;
        model.check_reply(got);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("small_value_set_table_core test failed");
        $finish;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value);
    int gap;
    gap = (!no_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    kind_i <= kind;
    value_i <= value;
    do @(posedge clk_i); while (full);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (model.replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return KIND_INSERT;
    if (r < insert_pct + (100 - insert_pct) / 2) return KIND_DELETE;
    if (r < 97) return KIND_QUERY;
    return KIND_SPARE;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  initial begin
    int insert_pct;
    model = new;
    no_idle = 1'b0;
    hold_cycles = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    push = 1'b0;
    kind_i = KIND_QUERY;
    value_i = '0;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'hFFFF_FFFF;
    pool[3] = 32'h0000_0000;
    pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL_SIZE; i++) begin
      pool[i] = (i % 2 == 0) ? pool[i - 1] ^ (32'h1 << $urandom_range(0, 31)) : $urandom;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, then the extreme values, a duplicate and the spare kind code.
    send_item(KIND_QUERY, pool[3]);
    send_item(KIND_DELETE, pool[0]);
    for (int i = 0; i < 4; i++) send_item(KIND_INSERT, pool[i]);
    send_item(KIND_INSERT, pool[1]);
    send_item(KIND_SPARE, pool[3]);
    send_item(KIND_DELETE, pool[1]);
    // Fill the table, overflow it, then remove the head so every entry shifts.
    for (int i = 4; i < 17; i++) send_item(KIND_INSERT, pool[i]);
    send_item(KIND_INSERT, 32'h1234_5678);
    send_item(KIND_INSERT, pool[2]);
    send_item(KIND_DELETE, pool[0]);

    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        insert_pct = 20 + 15 * $urandom_range(0, 5);
        if (n < RANDOM_ITEMS - 300) no_idle = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS - 300) no_idle = 1'b1;
      if (n == 500) hold_cycles = HOLD_OFF_CYCLES;
      if (n == 1000) wait_for_drain();
      send_item(pick_kind(insert_pct), pick_value());
    end
    @(negedge clk_i);
    push <= 1'b0;
    while (model.replies.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Ran %0d operations: %0d found the value, %0d deletes closed a gap,",
             model.ops, model.hits, model.shifts);
    $display("and %0d inserts were dropped on a full table.", model.dropped);
    if (model.errors == 0 && model.replies.size() == 0) begin
      $display("small_value_set_table_core test passed");
    end else begin
      $display("small_value_set_table_core test failed");
    end
    $finish;
  end

endmodule
